>>> hdl/sit_pkg.sv
// shared constants and types for the string intern table
// no dependencies
package sit_pkg;
	localparam int PoolBytes  = 32768;
	localparam int MaxEntries = 1024;
	localparam int PW = $clog2(PoolBytes);
	localparam int EW = $clog2(MaxEntries);
	localparam int LW = 15;
	localparam logic [LW-1:0] LenTop = {LW{1'b1}};

	typedef enum logic [2:0] {
		CMD_INTERN = 3'd0, CMD_LOOKUP = 3'd1, CMD_APPEND = 3'd2,
		CMD_RDLEN = 3'd3, CMD_RDBYTE = 3'd4, CMD_RSV5 = 3'd5,
		CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NOTFOUND = 3'd1, ST_TFULL = 3'd2,
		ST_PFULL = 3'd3, ST_BADIDX = 3'd4
	} status_t;

	// byte pool port bundle
	typedef struct packed {
		logic          we;
		logic [PW-1:0] waddr;
		logic [7:0]    wdata;
		logic [PW-1:0] raddr;
	} pool_req_t;

	// entry table port bundle
	typedef struct packed {
		logic          we;
		logic [EW-1:0] waddr;
		logic [PW-1:0] woff;
		logic [LW-1:0] wlen;
		logic [EW-1:0] raddr;
	} ent_req_t;
endpackage

>>> hdl/sit_pool.sv
// byte pool memory, one write and one registered read port
// depends on sit_pkg
module sit_pool (
	input  logic              clk,
	input  sit_pkg::pool_req_t req,
	output logic [7:0]        rdata
);
	logic [7:0] mem [sit_pkg::PoolBytes];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		rdata <= mem[req.raddr];
	end
endmodule

>>> hdl/sit_entries.sv
// entry table memory: offset and length per entry
// depends on sit_pkg
module sit_entries (
	input  logic                        clk,
	input  sit_pkg::ent_req_t           req,
	output logic [sit_pkg::PW-1:0]      roff,
	output logic [sit_pkg::LW-1:0]      rlen
);
	logic [sit_pkg::PW+sit_pkg::LW-1:0] mem [sit_pkg::MaxEntries];

	// write and registered read
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= {req.woff, req.wlen};
		{roff, rlen} <= mem[req.raddr];
	end
endmodule

>>> hdl/string_intern_table_unit.sv
// string intern table top level: control sequencer over pool and entry memories
// depends on sit_pkg, sit_pool, sit_entries
//
// One beat per start with busy low. A non-last string byte is written to the pool
// tail. The last byte of an intern or lookup walks the stored entries: an entry of
// other length passes through S_EREQ and S_ECHK, and an entry of equal length then
// alternates S_CMPA and S_CMPB for each compared byte (two pool reads per compared
// byte on the single pool read port). After its last beat, append keeps busy high
// through S_STORE, read length through S_RDENT, read byte through S_RDENT and S_RDB.
// Entry 0 and pool byte 0 are written by the S_INIT state after reset, during which
// busy is high. The result shows for one cycle on done; the receiver cannot stall.
module string_intern_table_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  cmd,
	input  logic [7:0]                  char_byte,
	input  logic                        is_last,
	input  logic                        is_empty,
	input  logic [9:0]                  entry_index,
	input  logic [14:0]                 char_pos,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [9:0]                  result_index,
	output logic                        was_found,
	output logic [14:0]                 entry_length,
	output logic [7:0]                  byte_out,
	output logic [10:0]                 entry_count
);
	localparam int PW = sit_pkg::PW;
	localparam int EW = sit_pkg::EW;
	localparam int LW = sit_pkg::LW;

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_EREQ  = 9'b000000100,
		S_ECHK  = 9'b000001000,
		S_CMPA  = 9'b000010000,
		S_CMPB  = 9'b000100000,
		S_STORE = 9'b001000000,
		S_RDENT = 9'b010000000,
		S_RDB   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [PW:0]   fill_q;
	logic [EW:0]   total_q;
	logic [LW-1:0] plen_q;
	logic [LW-1:0] len_q;
	logic [2:0]    cmd_q;
	logic [EW-1:0] scan_q;
	logic [LW-1:0] k_q;
	logic [PW-1:0] off_q;
	logic [LW-1:0] pos_q;
	logic [7:0]    cand_q;

	sit_pkg::pool_req_t preq;
	sit_pkg::ent_req_t  ereq;
	logic [7:0]    prd;
	logic [PW-1:0] eoff;
	logic [LW-1:0] elen;

	sit_pool u_pool (.clk(clk), .req(preq), .rdata(prd));
	sit_entries u_ent (.clk(clk), .req(ereq), .roff(eoff), .rlen(elen));

	logic [PW+1:0] at_w;
	logic [LW-1:0] nlen_w;
	logic          fits_w;
	logic [PW+1:0] need_w;
	logic [EW:0]   scan_next_w;

	assign busy = (state_q != S_IDLE);
	assign entry_count = 11'(total_q);
	assign at_w   = (PW+2)'(fill_q) + (PW+2)'(plen_q);
	assign nlen_w = (plen_q != sit_pkg::LenTop) ? plen_q + 1'b1 : plen_q;
	assign fits_w = (nlen_w != sit_pkg::LenTop) &&
		((PW+2)'(fill_q) + (PW+2)'(nlen_w) <= (PW+2)'(sit_pkg::PoolBytes));
	assign need_w = (PW+2)'(fill_q) + (PW+2)'(len_q) + 1'b1;
	assign scan_next_w = (EW+1)'(scan_q) + 1'b1;

	// memory port control
	always_comb begin
		preq = '0;
		ereq = '0;
		unique case (state_q)
			S_INIT: begin
				preq.we = 1'b1;
				ereq.we = 1'b1;
			end
			S_IDLE: begin
				if (start && cmd <= 3'(sit_pkg::CMD_APPEND) && !is_empty &&
						at_w < (PW+2)'(sit_pkg::PoolBytes)) begin
					preq.we = 1'b1;
					preq.waddr = PW'(at_w);
					preq.wdata = char_byte;
				end
				ereq.raddr = entry_index;
			end
			S_EREQ: ereq.raddr = scan_q;
			S_CMPA: begin
				preq.raddr = PW'(off_q + PW'(k_q));
			end
			S_CMPB: preq.raddr = PW'(fill_q + PW'(k_q));
			S_STORE: begin
				if (total_q < (EW+1)'(sit_pkg::MaxEntries) &&
						need_w <= (PW+2)'(sit_pkg::PoolBytes)) begin
					preq.we = 1'b1;
					preq.waddr = PW'(fill_q + PW'(len_q));
					ereq.we = 1'b1;
					ereq.waddr = EW'(total_q);
					ereq.woff = PW'(fill_q);
					ereq.wlen = len_q;
				end
			end
			S_RDENT: preq.raddr = PW'(eoff + PW'(pos_q));
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			fill_q <= (PW+1)'(1);
			total_q <= (EW+1)'(1);
			plen_q <= '0;
			len_q <= '0;
			cmd_q <= '0;
			scan_q <= '0;
			k_q <= '0;
			off_q <= '0;
			pos_q <= '0;
			cand_q <= '0;
			done <= 1'b0;
			status <= '0;
			result_index <= '0;
			was_found <= 1'b0;
			entry_length <= '0;
			byte_out <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					status <= 3'(sit_pkg::ST_OK);
					result_index <= '0;
					was_found <= 1'b0;
					entry_length <= '0;
					byte_out <= '0;
					if (start) begin
						cmd_q <= cmd;
						pos_q <= char_pos;
						if (cmd <= 3'(sit_pkg::CMD_APPEND)) begin
							if (is_empty) begin
								plen_q <= '0;
								was_found <= 1'b1;
								done <= 1'b1;
							end else if (!is_last) begin
								plen_q <= nlen_w;
							end else begin
								plen_q <= '0;
								len_q <= nlen_w;
								scan_q <= '0;
								if (!fits_w) begin
									status <= 3'(sit_pkg::ST_PFULL);
									done <= 1'b1;
								end else if (cmd == 3'(sit_pkg::CMD_APPEND))
									state_q <= S_STORE;
								else
									state_q <= S_EREQ;
							end
						end else if (cmd == 3'(sit_pkg::CMD_RDLEN) ||
								cmd == 3'(sit_pkg::CMD_RDBYTE)) begin
							if ((EW+1)'(entry_index) >= total_q) begin
								status <= 3'(sit_pkg::ST_BADIDX);
								done <= 1'b1;
							end else state_q <= S_RDENT;
						end
					end
				end
				S_EREQ: state_q <= S_ECHK;
				S_ECHK: begin
					off_q <= eoff;
					k_q <= '0;
					if (elen == len_q) state_q <= S_CMPA;
					else if (scan_next_w >= total_q) begin
						if (cmd_q == 3'(sit_pkg::CMD_LOOKUP)) begin
							status <= 3'(sit_pkg::ST_NOTFOUND);
							done <= 1'b1;
							state_q <= S_IDLE;
						end else state_q <= S_STORE;
					end else begin
						scan_q <= EW'(scan_next_w);
						state_q <= S_EREQ;
					end
				end
				// stored byte k-1 is in cand_q, staged byte k-1 arrives on prd
				S_CMPA: begin
					if (k_q != '0 && cand_q != prd) begin
						// mismatch, move to next entry
						if (scan_next_w >= total_q) begin
							if (cmd_q == 3'(sit_pkg::CMD_LOOKUP)) begin
								status <= 3'(sit_pkg::ST_NOTFOUND);
								done <= 1'b1;
								state_q <= S_IDLE;
							end else state_q <= S_STORE;
						end else begin
							scan_q <= EW'(scan_next_w);
							state_q <= S_EREQ;
						end
					end else if (k_q == len_q) begin
						result_index <= scan_q;
						was_found <= 1'b1;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_CMPB;
				end
				// capture stored byte k, step to the next position
				S_CMPB: begin
					cand_q <= prd;
					k_q <= k_q + 1'b1;
					state_q <= S_CMPA;
				end
				S_STORE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
					if (total_q >= (EW+1)'(sit_pkg::MaxEntries))
						status <= 3'(sit_pkg::ST_TFULL);
					else if (need_w > (PW+2)'(sit_pkg::PoolBytes))
						status <= 3'(sit_pkg::ST_PFULL);
					else begin
						result_index <= EW'(total_q);
						fill_q <= (PW+1)'(need_w);
						total_q <= total_q + 1'b1;
					end
				end
				S_RDENT: begin
					if (cmd_q == 3'(sit_pkg::CMD_RDLEN)) begin
						entry_length <= elen;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (pos_q > elen) begin
						status <= 3'(sit_pkg::ST_BADIDX);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_RDB;
				end
				S_RDB: begin
					byte_out <= prd;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// sequencer state stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	// entry count stays between one and the table size
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= (EW+1)'(1) && total_q <= (EW+1)'(sit_pkg::MaxEntries));
	// pool fill stays between one and the pool size
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= (PW+1)'(1) && fill_q <= (PW+1)'(sit_pkg::PoolBytes));
	// a found string always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_found |-> status == 3'(sit_pkg::ST_OK));
	// a result only shows once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy);
`endif
endmodule
